[design/domain_name_label_compare_macros.svh]
// ----------------------------------------------------------------------------
// domain name label compare assertion macros
// shared property templates for the checker
// ----------------------------------------------------------------------------
`ifndef DOMAIN_NAME_LABEL_COMPARE_MACROS_SVH
`define DOMAIN_NAME_LABEL_COMPARE_MACROS_SVH

// consequent must hold in the cycle after the trigger
`define DNLC_ASSERT_NEXT(name, clk, rst, trig, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the trigger
`define DNLC_ASSERT_SAME(name, clk, rst, trig, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error(msg);

// holds on the cycle after reset, without any disable
`define DNLC_ASSERT_RESET(name, clk, rst, cons, msg) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

[design/dnlc_pkg.sv]
// ----------------------------------------------------------------------------
// dnlc_pkg
// types and constants shared by the domain name label compare block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnlc_pkg;

   localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
   localparam logic [1:0] CMD_COMPARE       = 2'd2;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_byte;
      logic       first_absent;
      logic       second_absent;
   } req_type;

   typedef struct packed {
      logic signed [8:0] order_value;
      logic              overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_MATCH,
      ST_LABEL,
      ST_FWD
   } state_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_DEC,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_NEG,
      RES_POS,
      RES_DIFF
   } res_kind_type;

   typedef struct packed {
      logic         append_first;
      logic         append_second;
      logic         init_ptr;
      logic         clear_names;
      logic         lookback;
      ptr_op_type   op_a;
      ptr_op_type   op_b;
      logic         res_load;
      res_kind_type res_kind;
   } ctl_type;

   typedef struct packed {
      logic dot_a;
      logic dot_b;
      logic bytes_equal;
      logic a_above_start;
      logic b_above_start;
      logic a_past_end;
      logic b_past_end;
   } stat_type;

endpackage

[design/dnlc_datapath.sv]
// ----------------------------------------------------------------------------
// dnlc_datapath
// name stores, lengths, walk pointers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnlc_datapath #(
   parameter int MAX_NAME_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  dnlc_pkg::req_type  req_data,
   input  dnlc_pkg::ctl_type  ctl,
   output dnlc_pkg::stat_type stat,
   output dnlc_pkg::rsp_type  rsp_data
);

   localparam int PW = $clog2(MAX_NAME_BYTES + 1);
   localparam int AW = $clog2(MAX_NAME_BYTES);

   logic [7:0] mem_a [MAX_NAME_BYTES];
   logic [7:0] mem_b [MAX_NAME_BYTES];

   logic [PW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [PW-1:0] eff_a_ff, eff_a_in, eff_b_ff, eff_b_in;
   logic          zero_a_ff, zero_a_in, zero_b_ff, zero_b_in;
   logic          lead_a_ff, lead_a_in, lead_b_ff, lead_b_in;
   logic          trunc_ff, trunc_in;
   logic [PW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [7:0]    data_a_ff, data_b_ff;
   logic          rng_a_ff, rng_b_ff;
   dnlc_pkg::rsp_type res_ff, res_in;

   logic          full_a, full_b, wr_a, wr_b;
   logic [PW-1:0] sa, sb, addr_a, addr_b;
   logic [7:0]    byte_a, byte_b;

   assign full_a = (len_a_ff == PW'(MAX_NAME_BYTES));
   assign full_b = (len_b_ff == PW'(MAX_NAME_BYTES));
   assign wr_a   = ctl.append_first && !full_a;
   assign wr_b   = ctl.append_second && !full_b;
   assign sa     = PW'(lead_a_ff);
   assign sb     = PW'(lead_b_ff);

   // bookkeeping of lengths, first zero byte, leading dot and truncation
   always_comb begin
      len_a_in  = len_a_ff;
      len_b_in  = len_b_ff;
      eff_a_in  = eff_a_ff;
      eff_b_in  = eff_b_ff;
      zero_a_in = zero_a_ff;
      zero_b_in = zero_b_ff;
      lead_a_in = lead_a_ff;
      lead_b_in = lead_b_ff;
      trunc_in  = trunc_ff;
      if (wr_a) begin
         len_a_in = len_a_ff + PW'(1);
         if (len_a_ff == '0) begin
            lead_a_in = (req_data.char_byte == dnlc_pkg::DOT_CHAR);
         end
         if (!zero_a_ff) begin
            if (req_data.char_byte == 8'd0) begin
               zero_a_in = 1'b1;
            end else begin
               eff_a_in = eff_a_ff + PW'(1);
            end
         end
      end
      if (wr_b) begin
         len_b_in = len_b_ff + PW'(1);
         if (len_b_ff == '0) begin
            lead_b_in = (req_data.char_byte == dnlc_pkg::DOT_CHAR);
         end
         if (!zero_b_ff) begin
            if (req_data.char_byte == 8'd0) begin
               zero_b_in = 1'b1;
            end else begin
               eff_b_in = eff_b_ff + PW'(1);
            end
         end
      end
      if ((ctl.append_first && full_a) || (ctl.append_second && full_b)) begin
         trunc_in = 1'b1;
      end
      if (ctl.clear_names) begin
         len_a_in  = '0;
         len_b_in  = '0;
         eff_a_in  = '0;
         eff_b_in  = '0;
         zero_a_in = 1'b0;
         zero_b_in = 1'b0;
         lead_a_in = 1'b0;
         lead_b_in = 1'b0;
         trunc_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff  <= '0;
         len_b_ff  <= '0;
         eff_a_ff  <= '0;
         eff_b_ff  <= '0;
         zero_a_ff <= 1'b0;
         zero_b_ff <= 1'b0;
         lead_a_ff <= 1'b0;
         lead_b_ff <= 1'b0;
         trunc_ff  <= 1'b0;
      end else begin
         len_a_ff  <= len_a_in;
         len_b_ff  <= len_b_in;
         eff_a_ff  <= eff_a_in;
         eff_b_ff  <= eff_b_in;
         zero_a_ff <= zero_a_in;
         zero_b_ff <= zero_b_in;
         lead_a_ff <= lead_a_in;
         lead_b_ff <= lead_b_in;
         trunc_ff  <= trunc_in;
      end
   end

   // walk pointers
   always_comb begin
      pa_in = pa_ff;
      pb_in = pb_ff;
      case (ctl.op_a)
         dnlc_pkg::PTR_DEC: pa_in = pa_ff - PW'(1);
         dnlc_pkg::PTR_INC: pa_in = pa_ff + PW'(1);
         default:           pa_in = pa_ff;
      endcase
      case (ctl.op_b)
         dnlc_pkg::PTR_DEC: pb_in = pb_ff - PW'(1);
         dnlc_pkg::PTR_INC: pb_in = pb_ff + PW'(1);
         default:           pb_in = pb_ff;
      endcase
      if (ctl.init_ptr) begin
         pa_in = (eff_a_ff > sa) ? eff_a_ff - PW'(1) : sa;
         pb_in = (eff_b_ff > sb) ? eff_b_ff - PW'(1) : sb;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
   end

   // label scans look one byte to the left of the pointer
   assign addr_a = ctl.lookback ? pa_ff - PW'(1) : pa_ff;
   assign addr_b = ctl.lookback ? pb_ff - PW'(1) : pb_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[len_a_ff[AW-1:0]] <= req_data.char_byte;
      end
      data_a_ff <= mem_a[addr_a[AW-1:0]];
      rng_a_ff  <= (addr_a < eff_a_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[len_b_ff[AW-1:0]] <= req_data.char_byte;
      end
      data_b_ff <= mem_b[addr_b[AW-1:0]];
      rng_b_ff  <= (addr_b < eff_b_ff);
   end

   // bytes past the end of a name read as zero
   assign byte_a = rng_a_ff ? data_a_ff : 8'd0;
   assign byte_b = rng_b_ff ? data_b_ff : 8'd0;

   assign stat.dot_a         = (byte_a == dnlc_pkg::DOT_CHAR);
   assign stat.dot_b         = (byte_b == dnlc_pkg::DOT_CHAR);
   assign stat.bytes_equal   = (byte_a == byte_b);
   assign stat.a_above_start = (pa_ff > sa);
   assign stat.b_above_start = (pb_ff > sb);
   assign stat.a_past_end    = (pa_ff >= eff_a_ff);
   assign stat.b_past_end    = (pb_ff >= eff_b_ff);

   always_comb begin
      res_in            = res_ff;
      res_in.overflowed = trunc_ff;
      case (ctl.res_kind)
         dnlc_pkg::RES_NEG:  res_in.order_value = -9'sd1;
         dnlc_pkg::RES_POS:  res_in.order_value = 9'sd1;
         dnlc_pkg::RES_DIFF: res_in.order_value = $signed({1'b0, byte_a} - {1'b0, byte_b});
         default:            res_in.order_value = 9'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.res_load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_data = res_ff;

endmodule

[design/dnlc_controller.sv]
// ----------------------------------------------------------------------------
// dnlc_controller
// sequences appends and the label-order compare walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnlc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dnlc_pkg::req_type  req_data,
   input  dnlc_pkg::stat_type stat,
   output logic               busy,
   output logic               rsp_valid,
   output dnlc_pkg::ctl_type  ctl
);

   dnlc_pkg::state_type state_ff, state_in;
   logic eval_ff, eval_in;
   logic act_a_ff, act_a_in, act_b_ff, act_b_in;
   logic sub_a_ff, sub_a_in, sub_b_ff, sub_b_in;
   logic first_ff, first_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic stop_a, stop_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnlc_pkg::ST_IDLE;
         eval_ff      <= 1'b0;
         act_a_ff     <= 1'b0;
         act_b_ff     <= 1'b0;
         sub_a_ff     <= 1'b0;
         sub_b_ff     <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_ff      <= eval_in;
         act_a_ff     <= act_a_in;
         act_b_ff     <= act_b_in;
         sub_a_ff     <= sub_a_in;
         sub_b_ff     <= sub_b_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a label scan stops at the start or at a dot to the left
   assign stop_a = !stat.a_above_start || stat.dot_a;
   assign stop_b = !stat.b_above_start || stat.dot_b;

   always_comb begin
      state_in     = state_ff;
      eval_in      = 1'b0;
      act_a_in     = act_a_ff;
      act_b_in     = act_b_ff;
      sub_a_in     = sub_a_ff;
      sub_b_in     = sub_b_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      ctl          = '0;
      ctl.op_a     = dnlc_pkg::PTR_HOLD;
      ctl.op_b     = dnlc_pkg::PTR_HOLD;
      ctl.res_kind = dnlc_pkg::RES_ZERO;
      ctl.lookback = (state_ff == dnlc_pkg::ST_LABEL);

      unique case (state_ff)
         dnlc_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_data.cmd)
                  dnlc_pkg::CMD_APPEND_FIRST:  ctl.append_first = 1'b1;
                  dnlc_pkg::CMD_APPEND_SECOND: ctl.append_second = 1'b1;
                  dnlc_pkg::CMD_COMPARE: begin
                     if (req_data.first_absent || req_data.second_absent) begin
                        ctl.res_load    = 1'b1;
                        ctl.res_kind    = req_data.first_absent ? dnlc_pkg::RES_NEG
                                                                : dnlc_pkg::RES_POS;
                        ctl.clear_names = 1'b1;
                        rsp_valid_in    = 1'b1;
                     end else begin
                        ctl.init_ptr = 1'b1;
                        state_in     = dnlc_pkg::ST_TRIM;
                     end
                  end
                  default: ;
               endcase
            end
         end

         dnlc_pkg::ST_TRIM: begin
            if (!eval_ff) begin
               eval_in = 1'b1;
            end else begin
               // strip trailing dots on both names together
               if (stat.a_above_start && stat.dot_a) begin
                  ctl.op_a = dnlc_pkg::PTR_DEC;
               end
               if (stat.b_above_start && stat.dot_b) begin
                  ctl.op_b = dnlc_pkg::PTR_DEC;
               end
               if (!(stat.a_above_start && stat.dot_a) &&
                   !(stat.b_above_start && stat.dot_b)) begin
                  state_in = dnlc_pkg::ST_MATCH;
               end
            end
         end

         dnlc_pkg::ST_MATCH: begin
            if (!eval_ff) begin
               eval_in = 1'b1;
            end else if (stat.bytes_equal && stat.a_above_start && stat.b_above_start) begin
               ctl.op_a = dnlc_pkg::PTR_DEC;
               ctl.op_b = dnlc_pkg::PTR_DEC;
            end else if (!stat.bytes_equal) begin
               // mismatch: step past a dot, else scan back to the label start
               ctl.op_a = stat.dot_a ? dnlc_pkg::PTR_INC : dnlc_pkg::PTR_HOLD;
               ctl.op_b = stat.dot_b ? dnlc_pkg::PTR_INC : dnlc_pkg::PTR_HOLD;
               act_a_in = !stat.dot_a;
               act_b_in = !stat.dot_b;
               sub_a_in = 1'b0;
               sub_b_in = 1'b0;
               first_in = 1'b0;
               state_in = dnlc_pkg::ST_LABEL;
            end else if (stat.a_above_start) begin
               act_a_in = 1'b1;
               act_b_in = 1'b0;
               sub_a_in = 1'b1;
               sub_b_in = 1'b0;
               first_in = 1'b1;
               state_in = dnlc_pkg::ST_LABEL;
            end else if (stat.b_above_start) begin
               act_a_in = 1'b0;
               act_b_in = 1'b1;
               sub_a_in = 1'b0;
               sub_b_in = 1'b1;
               first_in = 1'b1;
               state_in = dnlc_pkg::ST_LABEL;
            end else begin
               ctl.res_load    = 1'b1;
               ctl.res_kind    = dnlc_pkg::RES_ZERO;
               ctl.clear_names = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = dnlc_pkg::ST_IDLE;
            end
         end

         dnlc_pkg::ST_LABEL: begin
            if (!eval_ff) begin
               eval_in = 1'b1;
            end else if (first_ff && sub_a_ff && stop_a) begin
               // dot right before the matched suffix: proper subdomain
               ctl.res_load    = 1'b1;
               ctl.res_kind    = dnlc_pkg::RES_NEG;
               ctl.clear_names = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = dnlc_pkg::ST_IDLE;
            end else if (first_ff && sub_b_ff && stop_b) begin
               ctl.res_load    = 1'b1;
               ctl.res_kind    = dnlc_pkg::RES_POS;
               ctl.clear_names = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = dnlc_pkg::ST_IDLE;
            end else begin
               first_in = 1'b0;
               act_a_in = act_a_ff && !stop_a;
               act_b_in = act_b_ff && !stop_b;
               if (act_a_ff && !stop_a) begin
                  ctl.op_a = dnlc_pkg::PTR_DEC;
               end
               if (act_b_ff && !stop_b) begin
                  ctl.op_b = dnlc_pkg::PTR_DEC;
               end
               if (!(act_a_ff && !stop_a) && !(act_b_ff && !stop_b)) begin
                  state_in = dnlc_pkg::ST_FWD;
               end
            end
         end

         dnlc_pkg::ST_FWD: begin
            if (!eval_ff) begin
               eval_in = 1'b1;
            end else if (!stat.bytes_equal || (stat.a_past_end && stat.b_past_end)) begin
               // both past the end compare equal from here on
               ctl.res_load    = 1'b1;
               ctl.res_kind    = dnlc_pkg::RES_DIFF;
               ctl.clear_names = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = dnlc_pkg::ST_IDLE;
            end else begin
               ctl.op_a = stat.a_past_end ? dnlc_pkg::PTR_HOLD : dnlc_pkg::PTR_INC;
               ctl.op_b = stat.b_past_end ? dnlc_pkg::PTR_HOLD : dnlc_pkg::PTR_INC;
            end
         end

         default: state_in = dnlc_pkg::ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != dnlc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/domain_name_label_compare.sv]
// ----------------------------------------------------------------------------
// domain_name_label_compare
// loads two domain names and orders them label by label from the right
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start, busy, req_data    taken when start && !busy
//  response  rsp_valid, rsp_data      one-cycle strobe, always taken
//
//  an append never raises busy; a compare with an absent name answers the next
//  cycle. other compares hold busy through each phase entered (trim, match,
//  label scan, forward walk) and through its pointer steps; the response comes
//  in the first cycle with busy low. each step is one registered read per store.
//  reset clears lengths, flags and controller state only; results are never
//  stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module domain_name_label_compare #(
   parameter int MAX_NAME_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dnlc_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output dnlc_pkg::rsp_type rsp_data
);

   dnlc_pkg::ctl_type  ctl;
   dnlc_pkg::stat_type stat;

   dnlc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   dnlc_datapath #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

[design/dnlc_checker.sv]
// ----------------------------------------------------------------------------
// dnlc_checker
// port-level checks on the domain name label compare block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "domain_name_label_compare_macros.svh"

module dnlc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input dnlc_pkg::req_type req_data,
   input logic              busy,
   input logic              rsp_valid,
   input dnlc_pkg::rsp_type rsp_data
);

   logic accept;
   assign accept = start && !busy;

   `DNLC_ASSERT_RESET(a_reset_quiet, clock, reset, !busy && !rsp_valid, "not idle after reset")

   `DNLC_ASSERT_NEXT(a_append_silent, clock, reset,
      accept && (req_data.cmd == dnlc_pkg::CMD_APPEND_FIRST ||
                 req_data.cmd == dnlc_pkg::CMD_APPEND_SECOND),
      !busy && !rsp_valid, "append request caused work or a response")

   `DNLC_ASSERT_NEXT(a_first_absent, clock, reset,
      accept && req_data.cmd == dnlc_pkg::CMD_COMPARE && req_data.first_absent,
      rsp_valid && rsp_data.order_value == -9'sd1 && !busy,
      "absent first name did not order lower")

   `DNLC_ASSERT_SAME(a_value_range, clock, reset, rsp_valid,
      rsp_data.order_value != -9'sd256, "order value out of range")

endmodule

bind domain_name_label_compare dnlc_checker u_dnlc_checker (.*);
